// File: design/c8exe_pkg.sv
// Shared types, codes and default sizes for the CHIP-8 execute unit.
package c8exe_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int SCREEN_COLS_DEF = 64;
    localparam int SCREEN_ROWS_DEF = 32;
    localparam int STACK_SLOTS_DEF = 15;

    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_OOB       = 3'd4,
        ST_UNIMPL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDX,
        S_RDY,
        S_EXEC,
        S_WRF,
        S_DADDR,
        S_DDATA,
        S_DONE
    } state_t;

    localparam logic [11:0] NNN_CLS = 12'h0E0;
    localparam logic [11:0] NNN_RET = 12'h0EE;
    localparam logic [3:0]  REG_VF  = 4'hF;
    localparam logic [3:0]  KEY_DOWN_SKIP = 4'hE;
    localparam logic [3:0]  KEY_UP_SKIP   = 4'h1;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] opcode;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
        logic [11:0] location;
        logic [7:0]  byte_in;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] next_pc;
        logic [15:0] index_value;
        logic [63:0] row_pixels;
    } result_t;

endpackage

// File: design/c8exe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module c8exe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/c8exe_alu.sv
// ALU for the 8xyN register group of the CHIP-8 instruction set.
module c8exe_alu (
    input  logic [3:0] op,
    input  logic [7:0] vx,
    input  logic [7:0] vy,
    output logic [7:0] res,
    output logic       flag,
    output logic       has_flag,
    output logic       known
);
    logic [8:0] sum;

    assign sum = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        res      = vx;
        flag     = 1'b0;
        has_flag = 1'b0;
        known    = 1'b1;
        case (op)
            4'h0: res = vy;
            4'h1: res = vx | vy;
            4'h2: res = vx & vy;
            4'h3: res = vx ^ vy;
            4'h4:
            begin
                res = sum[7:0];
                flag = sum[8];
                has_flag = 1'b1;
            end
            4'h5:
            begin
                res = vx - vy;
                flag = (vx >= vy);
                has_flag = 1'b1;
            end
            4'h6:
            begin
                res = {1'b0, vx[7:1]};
                flag = vx[0];
                has_flag = 1'b1;
            end
            4'h7:
            begin
                res = vy - vx;
                flag = (vy >= vx);
                has_flag = 1'b1;
            end
            4'hE:
            begin
                res = {vx[6:0], 1'b0};
                flag = vx[7];
                has_flag = 1'b1;
            end
            default: known = 1'b0;
        endcase
    end
endmodule

// File: design/chip8_instruction_execute_unit.sv
// CHIP-8 execute unit: sequencer, register file, main memory and frame buffer.
//
// An item is taken at a clock edge where start is high and busy is low. It is
// one of three commands: execute an opcode, write a byte to main memory, or read
// one display row. Every item gives exactly one result, shown on result for one
// cycle while done is high; the receiver cannot stall, so no backpressure exists.
// busy stays high from the accepting edge until the cycle after done.
// Sequence: an item passes from S_RDX through S_RDY and S_EXEC to S_DONE. ALU ops
// that write VF also pass through S_WRF. DRW loops over S_DADDR and S_DDATA once
// per sprite row and then writes VF in S_WRF. CLS needs no loop, since each
// display row carries a valid bit that is cleared at once. The sequence is set
// by the register file, which has a single read port and is read twice per item,
// and by the sprite loop, which reads one memory byte and one frame row per pass.
// Items are handled one at a time; another can be taken in the cycle after done.
// Reset clears PC, I, the stack pointer, the register file (through per-entry
// valid bits) and the display (through per-row valid bits). Main memory and the
// return stack hold unknown data until written; no clearing pass is needed.
module chip8_instruction_execute_unit #(
    parameter int MEM_BYTES   = c8exe_pkg::MEM_BYTES_DEF,
    parameter int SCREEN_COLS = c8exe_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = c8exe_pkg::SCREEN_ROWS_DEF,
    parameter int STACK_SLOTS = c8exe_pkg::STACK_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  c8exe_pkg::item_t    item,
    output logic                busy,
    output logic                done,
    output c8exe_pkg::result_t  result
);
    import c8exe_pkg::*;

    localparam int MA_W      = $clog2(MEM_BYTES);
    localparam int FA_W      = $clog2(SCREEN_ROWS);
    localparam int CW        = $clog2(SCREEN_COLS);
    localparam int COL_RECIP = (65536 + SCREEN_COLS - 1) / SCREEN_COLS;
    localparam int ROW_RECIP = (65536 + SCREEN_ROWS - 1) / SCREEN_ROWS;

    state_t      state_reg, state_next;
    item_t       item_reg;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] idx_reg, idx_next;
    logic [3:0]  sp_reg, sp_next;
    logic [15:0] stack_reg [16];
    logic        stack_we;
    logic [15:0] rf_valid_reg;
    logic [SCREEN_ROWS-1:0] row_valid_reg;
    logic        clr_frame;
    logic [7:0]  vx_reg, vx_next;
    logic [CW-1:0]   col0_reg, col0_next;
    logic [FA_W-1:0] row0_reg, row0_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        coll_reg, coll_next;
    logic        flag_reg, flag_next;
    status_t     status_reg, status_next;
    logic [63:0] row_out_reg, row_out_next;
    logic        rf_vq_reg, fr_vq_reg;

    logic            rf_we;
    logic [3:0]      rf_waddr, rf_raddr;
    logic [7:0]      rf_wdata, rf_rdata, rf_rd;
    logic            mem_we;
    logic [MA_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]      mem_rdata;
    logic            fr_we;
    logic [FA_W-1:0] fr_waddr, fr_raddr;
    logic [SCREEN_COLS-1:0] fr_wdata, fr_rdata, fr_rd;

    logic [3:0]  top, xi, yi, ni;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [15:0] pc2, pc4, bsum;
    logic [7:0]  alu_res;
    logic        alu_flag, alu_has_flag, alu_known;
    logic        pressed;
    logic [23:0] colq_full, rowq_full;
    logic [7:0]  col_mod, row_mod;
    logic [6:0]  rowsum;
    logic        row_in;
    logic [7:0]  rev;
    logic [SCREEN_COLS+7:0] wide;
    logic [SCREEN_COLS-1:0] mask;

    assign top = item_reg.opcode[15:12];
    assign xi  = item_reg.opcode[11:8];
    assign yi  = item_reg.opcode[7:4];
    assign ni  = item_reg.opcode[3:0];
    assign kk  = item_reg.opcode[7:0];
    assign nnn = item_reg.opcode[11:0];
    assign pc2 = pc_reg + 16'd2;
    assign pc4 = pc_reg + 16'd4;
    assign bsum = 16'(vx_reg) + 16'(nnn);

    assign rf_rd = rf_vq_reg ? rf_rdata : 8'd0;
    assign fr_rd = fr_vq_reg ? fr_rdata : '0;

    c8exe_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_raddr), .rdata(rf_rdata)
    );

    c8exe_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(item_reg.byte_in),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    c8exe_ram #(.WIDTH(SCREEN_COLS), .DEPTH(SCREEN_ROWS)) u_frame (
        .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fr_rdata)
    );

    c8exe_alu u_alu (
        .op(ni), .vx(vx_reg), .vy(rf_rd), .res(alu_res), .flag(alu_flag),
        .has_flag(alu_has_flag), .known(alu_known)
    );

    // Remainders by the screen size use a reciprocal multiply; exact for 8-bit values.
    assign colq_full = 24'(vx_reg) * 24'(COL_RECIP);
    assign rowq_full = 24'(rf_rd) * 24'(ROW_RECIP);
    assign col_mod   = vx_reg - 8'(16'(colq_full[23:16]) * 16'(SCREEN_COLS));
    assign row_mod   = rf_rd - 8'(16'(rowq_full[23:16]) * 16'(SCREEN_ROWS));

    assign pressed = (vx_reg <= 8'd15) && item_reg.key_mask[vx_reg[3:0]];

    assign rowsum = 7'(row0_reg) + 7'(cnt_reg);
    assign row_in = (rowsum < 7'(SCREEN_ROWS));

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            rev[j] = mem_rdata[7-j];
        end
    end

    assign wide = (SCREEN_COLS+8)'(rev) << col0_reg;
    assign mask = wide[SCREEN_COLS-1:0];

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        idx_next     = idx_reg;
        sp_next      = sp_reg;
        stack_we     = 1'b0;
        clr_frame    = 1'b0;
        vx_next      = vx_reg;
        col0_next    = col0_reg;
        row0_next    = row0_reg;
        cnt_next     = cnt_reg;
        coll_next    = coll_reg;
        flag_next    = flag_reg;
        status_next  = status_reg;
        row_out_next = row_out_reg;
        rf_we        = 1'b0;
        rf_waddr     = xi;
        rf_wdata     = alu_res;
        rf_raddr     = xi;
        mem_we       = 1'b0;
        mem_waddr    = item_reg.location[MA_W-1:0];
        mem_raddr    = MA_W'(idx_reg + 16'(cnt_reg));
        fr_we        = 1'b0;
        fr_waddr     = FA_W'(rowsum);
        fr_wdata     = fr_rd ^ mask;
        fr_raddr     = item_reg.location[FA_W-1:0];
        done         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RDX;
                end
            end
            S_RDX:
            begin
                rf_raddr = (top == 4'hB) ? 4'h0 : xi;
                state_next = S_RDY;
            end
            S_RDY:
            begin
                rf_raddr = yi;
                vx_next = rf_rd;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                row_out_next = '0;
                state_next = S_DONE;
                case (item_reg.cmd)
                    CMD_WRITE:
                    begin
                        if (32'(item_reg.location) < MEM_BYTES)
                        begin
                            mem_we = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_OOB;
                        end
                    end
                    CMD_READ:
                    begin
                        if (32'(item_reg.location) < SCREEN_ROWS)
                        begin
                            row_out_next = 64'(fr_rd);
                        end
                        else
                        begin
                            status_next = ST_OOB;
                        end
                    end
                    CMD_EXEC:
                    begin
                        pc_next = pc2;
                        case (top)
                            4'h0:
                            begin
                                if (nnn == NNN_CLS)
                                begin
                                    clr_frame = 1'b1;
                                end
                                else if (nnn == NNN_RET)
                                begin
                                    if (sp_reg == 4'd0)
                                    begin
                                        status_next = ST_UNDERFLOW;
                                    end
                                    else
                                    begin
                                        sp_next = sp_reg - 4'd1;
                                        pc_next = stack_reg[sp_reg - 4'd1];
                                    end
                                end
                                else
                                begin
                                    idx_next = 16'(nnn);
                                end
                            end
                            4'h1: pc_next = 16'(nnn);
                            4'h2:
                            begin
                                if (32'(sp_reg) >= STACK_SLOTS)
                                begin
                                    status_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    stack_we = 1'b1;
                                    pc_next = 16'(nnn);
                                    sp_next = sp_reg + 4'd1;
                                end
                            end
                            4'h3: if (vx_reg == kk) pc_next = pc4;
                            4'h4: if (vx_reg != kk) pc_next = pc4;
                            4'h5: if (vx_reg == rf_rd) pc_next = pc4;
                            4'h6:
                            begin
                                rf_we = 1'b1;
                                rf_wdata = kk;
                            end
                            4'h7:
                            begin
                                rf_we = 1'b1;
                                rf_wdata = vx_reg + kk;
                            end
                            4'h8:
                            begin
                                if (alu_known)
                                begin
                                    rf_we = 1'b1;
                                    if (alu_has_flag)
                                    begin
                                        flag_next = alu_flag;
                                        state_next = S_WRF;
                                    end
                                end
                                else
                                begin
                                    status_next = ST_UNKNOWN;
                                end
                            end
                            4'h9: if (vx_reg != rf_rd) pc_next = pc4;
                            4'hA: idx_next = 16'(nnn);
                            4'hB:
                            begin
                                pc_next = bsum;
                                if (17'(bsum) >= 17'(MEM_BYTES))
                                begin
                                    status_next = ST_OOB;
                                end
                            end
                            4'hC:
                            begin
                                rf_we = 1'b1;
                                rf_wdata = item_reg.random_byte & kk;
                            end
                            4'hD:
                            begin
                                if (17'(idx_reg) + 17'(ni) > 17'(MEM_BYTES))
                                begin
                                    status_next = ST_OOB;
                                end
                                else
                                begin
                                    col0_next = CW'(col_mod);
                                    row0_next = FA_W'(row_mod);
                                    cnt_next = 4'd0;
                                    coll_next = 1'b0;
                                    state_next = S_DADDR;
                                end
                            end
                            4'hE:
                            begin
                                if (ni == KEY_DOWN_SKIP)
                                begin
                                    if (pressed) pc_next = pc4;
                                end
                                else if (ni == KEY_UP_SKIP)
                                begin
                                    if (!pressed) pc_next = pc4;
                                end
                                else
                                begin
                                    status_next = ST_UNKNOWN;
                                end
                            end
                            default: status_next = ST_UNIMPL;
                        endcase
                    end
                    default: status_next = ST_UNKNOWN;
                endcase
            end
            S_WRF:
            begin
                rf_we = 1'b1;
                rf_waddr = REG_VF;
                rf_wdata = {7'd0, flag_reg};
                state_next = S_DONE;
            end
            S_DADDR:
            begin
                fr_raddr = FA_W'(rowsum);
                if (cnt_reg == ni)
                begin
                    flag_next = coll_reg;
                    state_next = S_WRF;
                end
                else
                begin
                    state_next = S_DDATA;
                end
            end
            S_DDATA:
            begin
                // The sprite byte and the target row are both on the RAM outputs now.
                fr_raddr = FA_W'(rowsum);
                if (row_in)
                begin
                    fr_we = 1'b1;
                    coll_next = coll_reg | (|(fr_rd & mask));
                end
                cnt_next = cnt_reg + 4'd1;
                state_next = S_DADDR;
            end
            S_DONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 16'd0;
            idx_reg       <= 16'd0;
            sp_reg        <= 4'd0;
            rf_valid_reg  <= 16'd0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (clr_frame)
            begin
                row_valid_reg <= '0;
            end
            else if (fr_we)
            begin
                row_valid_reg[fr_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            item_reg <= item;
        end
        if (stack_we)
        begin
            stack_reg[sp_reg] <= pc2;
        end
        vx_reg      <= vx_next;
        col0_reg    <= col0_next;
        row0_reg    <= row0_next;
        cnt_reg     <= cnt_next;
        coll_reg    <= coll_next;
        flag_reg    <= flag_next;
        status_reg  <= status_next;
        row_out_reg <= row_out_next;
        rf_vq_reg   <= rf_valid_reg[rf_raddr];
        fr_vq_reg   <= row_valid_reg[fr_raddr];
    end

    assign busy = (state_reg != S_IDLE);
    assign result.status      = status_reg;
    assign result.next_pc     = pc_reg;
    assign result.index_value = idx_reg;
    assign result.row_pixels  = row_out_reg;
endmodule
